// File: hw/rtl/dgsh_pkg.sv
// Package for the guide species hit table.
// Holds the sizes, character codes and the job and entry types.
// Used by every module of the block but dgsh_ram.
package dgsh_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SPECIES_COUNT = 64;
  localparam int MAX_GUIDE     = 32;

  localparam logic [5:0] GUIDE_LEN_RESET = 6'd20;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'b00;
  localparam logic [1:0] CODE_C = 2'b01;
  localparam logic [1:0] CODE_G = 2'b10;
  localparam logic [1:0] CODE_T = 2'b11;

  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  score;
    logic [15:0] species;
    logic        bad_char;
  } job_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] mask;
    logic [7:0]  score;
  } entry_t;

endpackage

// File: hw/rtl/dna_guide_species_hit_table.sv
// Guide species hit table, top level. Characters are accepted back to back while busy is low;
// busy is high only while both queue slots hold completed guides. The table engine scans
// the filled entries one at a time, each with a RAM read (RD) and a compare (CMP); the
// registered strobe follows the compare that matches, or the DEC state after the last
// entry misses or when the table is empty. The receiver cannot stall. Synchronous
// active-low reset clears key, counts, union and entry count; the table needs no clearing.
module dna_guide_species_hit_table #(
  parameter int TABLE_DEPTH   = dgsh_pkg::TABLE_DEPTH,
  parameter int SPECIES_COUNT = dgsh_pkg::SPECIES_COUNT,
  parameter int MAX_GUIDE     = dgsh_pkg::MAX_GUIDE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_base_char,
  input  logic        in_guide_start,
  input  logic [7:0]  in_guide_score,
  input  logic [15:0] in_species_index,
  output logic        out_valid,
  output logic [63:0] out_guide_key,
  output logic [9:0]  out_entry_index,
  output logic        out_is_new,
  output logic        out_table_full,
  output logic        out_bad_char_seen,
  output logic        out_bad_species,
  output logic [63:0] out_entry_species_mask,
  output logic [7:0]  out_entry_score,
  output logic [63:0] out_covered_mask
);

  logic           push, pop, q_empty, q_full;
  dgsh_pkg::job_t push_job, q_head;

  assign busy = q_full;

  dgsh_front #(.MAX_GUIDE(MAX_GUIDE)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .accept          (start && !busy),
    .in_base_char    (in_base_char),
    .in_guide_start  (in_guide_start),
    .in_guide_score  (in_guide_score),
    .in_species_index(in_species_index),
    .push            (push),
    .push_job        (push_job)
  );

  dgsh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .empty   (q_empty),
    .full    (q_full),
    .head    (q_head)
  );

  dgsh_back #(.TABLE_DEPTH(TABLE_DEPTH), .SPECIES_COUNT(SPECIES_COUNT)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_guide_key         (out_guide_key),
    .out_entry_index       (out_entry_index),
    .out_is_new            (out_is_new),
    .out_table_full        (out_table_full),
    .out_bad_char_seen     (out_bad_char_seen),
    .out_bad_species       (out_bad_species),
    .out_entry_species_mask(out_entry_species_mask),
    .out_entry_score       (out_entry_score),
    .out_covered_mask      (out_covered_mask)
  );

endmodule

// File: hw/rtl/dgsh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dgsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dgsh_front.sv
// Front end: accepts characters, packs them into the key and emits a job
// per completed guide. Depends on dgsh_pkg.
module dgsh_front #(
  parameter int MAX_GUIDE = dgsh_pkg::MAX_GUIDE
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_data,
  input  logic          accept,
  input  logic [7:0]    in_base_char,
  input  logic          in_guide_start,
  input  logic [7:0]    in_guide_score,
  input  logic [15:0]   in_species_index,
  output logic          push,
  output dgsh_pkg::job_t push_job
);

  localparam logic [5:0] MaxLen = 6'(MAX_GUIDE);

  logic [5:0]  guide_len_r;
  logic [63:0] key_r, key_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        bad_r, bad_nxt;
  logic [5:0]  len;
  logic [1:0]  code;
  logic        bad_now;
  logic [63:0] kmask;
  logic        done;

  always_comb begin
    len = guide_len_r;
    if (len == 6'd0) begin
      len = 6'd1;
    end else if (len > MaxLen) begin
      len = MaxLen;
    end
    bad_now = 1'b0;
    unique case (in_base_char)
      dgsh_pkg::CHAR_A: code = dgsh_pkg::CODE_A;
      dgsh_pkg::CHAR_C: code = dgsh_pkg::CODE_C;
      dgsh_pkg::CHAR_G: code = dgsh_pkg::CODE_G;
      dgsh_pkg::CHAR_T: code = dgsh_pkg::CODE_T;
      default: begin
        code    = dgsh_pkg::CODE_A;
        bad_now = 1'b1;
      end
    endcase
    if (len >= 6'd32) begin
      kmask = '1;
    end else begin
      kmask = (64'd1 << {len, 1'b0}) - 64'd1;
    end
    key_nxt = (((in_guide_start ? 64'd0 : key_r) << 2) | {62'd0, code}) & kmask;
    cnt_nxt = (in_guide_start ? 6'd0 : cnt_r) + 6'd1;
    bad_nxt = (in_guide_start ? 1'b0 : bad_r) | bad_now;
    done    = cnt_nxt >= len;
    push    = accept && done;
    push_job.key      = key_nxt;
    push_job.score    = in_guide_score;
    push_job.species  = in_species_index;
    push_job.bad_char = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guide_len_r <= dgsh_pkg::GUIDE_LEN_RESET;
      key_r       <= '0;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        guide_len_r <= cfg_data;
      end
      if (accept) begin
        if (done) begin
          key_r <= '0;
          cnt_r <= '0;
          bad_r <= 1'b0;
        end else begin
          key_r <= key_nxt;
          cnt_r <= cnt_nxt;
          bad_r <= bad_nxt;
        end
      end
    end
  end

endmodule

// File: hw/rtl/dgsh_queue.sv
// Two-entry job queue between the front end and the table engine.
// Depends on dgsh_pkg.
module dgsh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dgsh_pkg::job_t push_job,
  input  logic           pop,
  output logic           empty,
  output logic           full,
  output dgsh_pkg::job_t head
);

  dgsh_pkg::job_t slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign empty = cnt_r == 2'd0;
  assign full  = cnt_r == 2'd2;
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/dgsh_back.sv
// Table engine: searches the filled part of the table one entry at a time, updates a hit
// or inserts a miss (valid species, room left only) and reports. Depends on dgsh_pkg, dgsh_ram.
module dgsh_back #(
  parameter int TABLE_DEPTH   = dgsh_pkg::TABLE_DEPTH,
  parameter int SPECIES_COUNT = dgsh_pkg::SPECIES_COUNT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  dgsh_pkg::job_t q_head,
  output logic           pop,
  output logic           out_valid,
  output logic [63:0]    out_guide_key,
  output logic [9:0]     out_entry_index,
  output logic           out_is_new,
  output logic           out_table_full,
  output logic           out_bad_char_seen,
  output logic           out_bad_species,
  output logic [63:0]    out_entry_species_mask,
  output logic [7:0]     out_entry_score,
  output logic [63:0]    out_covered_mask
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(dgsh_pkg::entry_t);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {IDLE, RD, CMP, DEC} state_t;

  state_t          state_r;
  dgsh_pkg::job_t  job_r;
  logic [AW-1:0]   idx_r;
  logic [CW-1:0]   count_r;
  logic [63:0]     union_r;

  logic            we;
  logic [AW-1:0]   waddr;
  dgsh_pkg::entry_t wentry, rentry;
  logic [EW-1:0]   rdata;
  logic            bad_sp;
  logic [63:0]     sp_bit;
  logic            hit;
  logic            last;
  logic [AW+9:0]   idx_ext, cnt_ext;

  dgsh_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(idx_r),
    .rdata(rdata)
  );

  always_comb begin
    rentry  = rdata;
    bad_sp  = job_r.species >= 16'(SPECIES_COUNT);
    sp_bit  = 64'd1 << job_r.species[5:0];
    hit     = (state_r == CMP) && (rentry.key == job_r.key);
    last    = ({1'b0, idx_r} + (AW+1)'(1)) == (AW+1)'(count_r);
    pop     = (state_r == IDLE) && !q_empty;
    idx_ext = {10'd0, idx_r};
    cnt_ext = (AW+10)'(count_r);
    we      = 1'b0;
    waddr   = idx_r;
    wentry  = rentry;
    if (hit && !bad_sp) begin
      we          = 1'b1;
      wentry.mask = rentry.mask | sp_bit;
    end else if (state_r == DEC && count_r != Depth && !bad_sp) begin
      we           = 1'b1;
      waddr        = AW'(count_r);
      wentry.key   = job_r.key;
      wentry.mask  = sp_bit;
      wentry.score = job_r.score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      count_r   <= '0;
      union_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (!q_empty) begin
            job_r   <= q_head;
            idx_r   <= '0;
            state_r <= (count_r == '0) ? DEC : RD;
          end
        end
        RD: state_r <= CMP;
        CMP: begin
          if (hit) begin
            out_valid              <= 1'b1;
            out_guide_key          <= job_r.key;
            out_entry_index        <= idx_ext[9:0];
            out_is_new             <= 1'b0;
            out_table_full         <= 1'b0;
            out_bad_char_seen      <= job_r.bad_char;
            out_bad_species        <= bad_sp;
            out_entry_species_mask <= bad_sp ? rentry.mask : (rentry.mask | sp_bit);
            out_entry_score        <= rentry.score;
            out_covered_mask       <= bad_sp ? union_r : (union_r | sp_bit);
            if (!bad_sp) begin
              union_r <= union_r | sp_bit;
            end
            state_r <= IDLE;
          end else if (last) begin
            state_r <= DEC;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= RD;
          end
        end
        DEC: begin
          out_valid         <= 1'b1;
          out_guide_key     <= job_r.key;
          out_bad_char_seen <= job_r.bad_char;
          out_bad_species   <= bad_sp;
          out_table_full    <= count_r == Depth;
          if (count_r != Depth && !bad_sp) begin
            // A miss with room and a valid species becomes a new entry.
            out_entry_index        <= cnt_ext[9:0];
            out_is_new             <= 1'b1;
            out_entry_species_mask <= sp_bit;
            out_entry_score        <= job_r.score;
            out_covered_mask       <= union_r | sp_bit;
            union_r                <= union_r | sp_bit;
            count_r                <= count_r + CW'(1);
          end else begin
            out_entry_index        <= '0;
            out_is_new             <= 1'b0;
            out_entry_species_mask <= '0;
            out_entry_score        <= '0;
            out_covered_mask       <= union_r;
          end
          state_r <= IDLE;
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  a_out_from_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == CMP || $past(state_r) == DEC))
    else $error("result strobe without a decision");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Depth)
    else $error("entry count beyond table depth");

  a_read_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RD |-> count_r != '0)
    else $error("table read with no entries");

endmodule
